[hw/rtl/jtrl_pkg.sv]
`default_nettype none
package jtrl_pkg;

   localparam int JOINTS = 7;
   localparam int JOINT_W = 3;
   localparam int JIDX_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;
   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

   localparam logic [16:0] ALPHA_ONE = 17'd65536;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 31;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BLEND_ALPHA = 2'd0,
      CSR_VELOCITY_STEP_LIMIT = 2'd1,
      CSR_ACCEL_STEP_LIMIT = 2'd2,
      CSR_EXTRA_STEP_LIMIT = 2'd3
   } csr_index_type;

   typedef enum logic {
      FUNC_UPDATE = 1'b0,
      FUNC_RESET = 1'b1
   } func_type;

   typedef struct packed {
      logic [0:0] func;
      logic [JOINT_W-1:0] joint;
      logic signed [31:0] target_position;
      logic signed [31:0] reference_position;
   } req_word_type;

   typedef struct packed {
      logic [JOINT_W-1:0] out_joint;
      logic signed [31:0] command_position;
      logic signed [31:0] command_step;
   } rsp_word_type;

   typedef struct packed {
      logic is_reset;
      logic [JIDX_W-1:0] joint;
      logic signed [31:0] target;
      logic signed [31:0] reference;
   } cmd_type;

   typedef struct packed {
      logic [16:0] blend_alpha;
      logic [30:0] velocity_step_limit;
      logic [30:0] accel_step_limit;
      logic [30:0] extra_step_limit;
   } cfg_type;

   typedef struct packed {
      logic push;
      logic full;
   } cmdq_wr_type;

   typedef struct packed {
      logic pop;
      logic empty;
   } cmdq_rd_type;

endpackage
`default_nettype wire

[hw/rtl/jtrl_front.sv]
`default_nettype none
module jtrl_front (
   input  wire                    req_push,
   input  jtrl_pkg::req_word_type req_word,
   output logic                   req_full,
   input  wire                    cmdq_full,
   output logic                   cmdq_push,
   output jtrl_pkg::cmd_type      cmdq_word
);
   import jtrl_pkg::*;

   logic in_range;
   logic is_reset;

   assign is_reset = (func_type'(req_word.func) == FUNC_RESET);
   assign in_range = ({1'b0, req_word.joint} < (JOINT_W + 1)'(JOINTS));

   assign req_full = cmdq_full;

   // drop updates for joints that do not exist
   assign cmdq_push = req_push && !cmdq_full && (is_reset || in_range);

   always_comb begin
      cmdq_word.is_reset = is_reset;
      cmdq_word.joint = JIDX_W'(req_word.joint);
      cmdq_word.target = req_word.target_position;
      cmdq_word.reference = req_word.reference_position;
   end

endmodule
`default_nettype wire

[hw/rtl/jtrl_cmd_queue.sv]
`default_nettype none
module jtrl_cmd_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  jtrl_pkg::cmd_type     push_word,
   input  wire                   pop,
   output jtrl_pkg::cmd_type     head,
   output jtrl_pkg::cmdq_wr_type wr_status,
   output jtrl_pkg::cmdq_rd_type rd_status
);
   import jtrl_pkg::*;

   cmd_type entry_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_PTR_W:0] count_ff, count_in;
   logic do_push, do_pop;

   assign wr_status.full = (count_ff == (CMDQ_PTR_W + 1)'(CMDQ_DEPTH));
   assign wr_status.push = do_push;
   assign rd_status.empty = (count_ff == '0);
   assign rd_status.pop = do_pop;

   assign do_push = push && !wr_status.full;
   assign do_pop = pop && !rd_status.empty;
   assign head = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/jtrl_back.sv]
`default_nettype none
module jtrl_back (
   input  wire                    clock,
   input  wire                    reset,
   input  jtrl_pkg::cfg_type      cfg,
   input  jtrl_pkg::cmd_type      cmd,
   input  jtrl_pkg::cmdq_rd_type  cmdq_status,
   output logic                   cmd_pop,
   output jtrl_pkg::rsp_word_type rsp_word,
   output logic                   rsp_empty,
   input  wire                    rsp_pop
);
   import jtrl_pkg::*;

   // per-joint state
   logic signed [31:0] pos_ff [JOINTS];
   logic signed [31:0] step_ff [JOINTS];
   logic [JOINTS-1:0] seeded_ff, seeded_in;

   // stage valids and joints
   logic a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff;
   logic [JIDX_W-1:0] a_joint_ff, b_joint_ff, c_joint_ff, d_joint_ff;
   logic signed [31:0] a_prev_q_ff, b_prev_q_ff, c_prev_q_ff, d_prev_q_ff;
   logic signed [31:0] a_prev_dq_ff, b_prev_dq_ff, c_prev_dq_ff;

   logic signed [32:0] a_diff_ff;
   logic [16:0] a_alpha_ff, a_ialpha_ff;
   logic signed [50:0] b_p1_ff, b_p2_ff;
   logic signed [31:0] c_vel_ff;
   logic signed [33:0] d_acc_ff;

   // result buffer
   rsp_word_type rsp_ff [2];
   logic wr_sel_ff, rd_sel_ff;
   logic [1:0] rsp_cnt_ff, rsp_cnt_in;

   logic adv, hazard, issue, do_reset, rsp_push, do_rsp_pop;
   logic [16:0] alpha_c;
   logic signed [31:0] seed_q, seed_dq;
   logic signed [51:0] sum;
   logic signed [35:0] blended;
   logic signed [35:0] vlim_w;
   logic signed [32:0] dv, alim_w;
   logic signed [32:0] delta;
   logic [30:0] bound;
   logic signed [33:0] bound_w;
   logic signed [31:0] step_c;
   logic signed [32:0] pos_w;
   logic signed [31:0] pos_sat;
   logic signed [32:0] step_w;

   assign adv = (rsp_cnt_ff != 2'd2);

   assign hazard = (a_valid_ff && a_joint_ff == cmd.joint)
                || (b_valid_ff && b_joint_ff == cmd.joint)
                || (c_valid_ff && c_joint_ff == cmd.joint)
                || (d_valid_ff && d_joint_ff == cmd.joint);

   // a reset waits for the pipeline to drain so in-flight writes land first
   assign do_reset = !cmdq_status.empty && cmd.is_reset
                  && !a_valid_ff && !b_valid_ff && !c_valid_ff && !d_valid_ff;
   assign issue = !cmdq_status.empty && !cmd.is_reset && adv && !hazard;
   assign cmd_pop = issue || do_reset;

   always_comb begin
      alpha_c = (cfg.blend_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.blend_alpha;
      seed_q = seeded_ff[cmd.joint] ? pos_ff[cmd.joint] : cmd.reference;
      seed_dq = seeded_ff[cmd.joint] ? step_ff[cmd.joint] : 32'sd0;
   end

   // stage C: blend round and velocity clamp
   always_comb begin
      sum = 52'(b_p1_ff) + 52'(b_p2_ff) + 52'sd32768;
      blended = 36'(sum >>> 16);
      vlim_w = $signed({5'd0, cfg.velocity_step_limit});
   end

   // stage D: acceleration clamp
   always_comb begin
      dv = 33'(c_vel_ff) - 33'(c_prev_dq_ff);
      alim_w = $signed({2'd0, cfg.accel_step_limit});
      if (dv > alim_w) begin
         delta = alim_w;
      end else if (dv < -alim_w) begin
         delta = -alim_w;
      end else begin
         delta = dv;
      end
   end

   // final: step bound, position saturation
   always_comb begin
      if (cfg.extra_step_limit != '0 && cfg.extra_step_limit < cfg.velocity_step_limit) begin
         bound = cfg.extra_step_limit;
      end else begin
         bound = cfg.velocity_step_limit;
      end
      bound_w = $signed({3'd0, bound});
      if (d_acc_ff > bound_w) begin
         step_c = 32'(bound_w);
      end else if (d_acc_ff < -bound_w) begin
         step_c = 32'(-bound_w);
      end else begin
         step_c = 32'(d_acc_ff);
      end
      pos_w = 33'(d_prev_q_ff) + 33'(step_c);
      if (pos_w > 33'sd2147483647) begin
         pos_sat = 32'sh7fffffff;
      end else if (pos_w < -33'sd2147483648) begin
         pos_sat = 32'sh80000000;
      end else begin
         pos_sat = 32'(pos_w);
      end
      step_w = 33'(pos_sat) - 33'(d_prev_q_ff);
   end

   assign rsp_push = adv && d_valid_ff;
   assign do_rsp_pop = rsp_pop && !rsp_empty;
   assign rsp_empty = (rsp_cnt_ff == 2'd0);
   assign rsp_word = rsp_ff[rd_sel_ff];

   always_comb begin
      seeded_in = seeded_ff;
      if (do_reset) begin
         seeded_in = '0;
      end else if (rsp_push) begin
         seeded_in[d_joint_ff] = 1'b1;
      end
      rsp_cnt_in = rsp_cnt_ff;
      if (rsp_push && !do_rsp_pop) begin
         rsp_cnt_in = rsp_cnt_ff + 1'b1;
      end else if (do_rsp_pop && !rsp_push) begin
         rsp_cnt_in = rsp_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seeded_ff <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         wr_sel_ff <= 1'b0;
         rd_sel_ff <= 1'b0;
         rsp_cnt_ff <= '0;
      end else begin
         seeded_ff <= seeded_in;
         rsp_cnt_ff <= rsp_cnt_in;
         if (rsp_push) begin
            wr_sel_ff <= !wr_sel_ff;
         end
         if (do_rsp_pop) begin
            rd_sel_ff <= !rd_sel_ff;
         end
         if (adv) begin
            a_valid_ff <= issue;
            b_valid_ff <= a_valid_ff;
            c_valid_ff <= b_valid_ff;
            d_valid_ff <= c_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_joint_ff <= cmd.joint;
         a_prev_q_ff <= seed_q;
         a_prev_dq_ff <= seed_dq;
         a_diff_ff <= 33'(cmd.target) - 33'(seed_q);
         a_alpha_ff <= alpha_c;
         a_ialpha_ff <= ALPHA_ONE - alpha_c;

         b_joint_ff <= a_joint_ff;
         b_prev_q_ff <= a_prev_q_ff;
         b_prev_dq_ff <= a_prev_dq_ff;
         b_p1_ff <= $signed({1'b0, a_alpha_ff}) * a_diff_ff;
         b_p2_ff <= $signed({1'b0, a_ialpha_ff}) * 51'(a_prev_dq_ff);

         c_joint_ff <= b_joint_ff;
         c_prev_q_ff <= b_prev_q_ff;
         c_prev_dq_ff <= b_prev_dq_ff;
         if (blended > vlim_w) begin
            c_vel_ff <= 32'(vlim_w);
         end else if (blended < -vlim_w) begin
            c_vel_ff <= 32'(-vlim_w);
         end else begin
            c_vel_ff <= 32'(blended);
         end

         d_joint_ff <= c_joint_ff;
         d_prev_q_ff <= c_prev_q_ff;
         d_acc_ff <= 34'(c_prev_dq_ff) + 34'(delta);
      end
      if (rsp_push) begin
         pos_ff[d_joint_ff] <= pos_sat;
         step_ff[d_joint_ff] <= 32'(step_w);
         rsp_ff[wr_sel_ff].out_joint <= JOINT_W'(d_joint_ff);
         rsp_ff[wr_sel_ff].command_position <= pos_sat;
         rsp_ff[wr_sel_ff].command_step <= 32'(step_w);
      end
   end

endmodule
`default_nettype wire

[hw/rtl/joint_target_rate_limiter.sv]
`default_nettype none
// Joint setpoint smoother. Each req word either updates one joint (target and
// seed reference, Q8.24 radians) or resets all joints to unseeded; one rsp word
// comes back per valid update with the new command position and applied step,
// limited by the blend weight, velocity, acceleration and extra step limits in
// the csr registers. Resets and updates to joints beyond the joint count give
// no rsp word. It takes one req word per cycle while req_full is low; each
// update passes the pipeline steps seed read, multiply, blend clamp,
// acceleration clamp, final bound and write-back. An update waits at the
// command queue head while an earlier update to the same joint is still in
// the pipeline, a reset until it is empty; joints sent in turn keep one word
// per cycle while rsp is popped. Write csr registers only while idle.
module joint_target_rate_limiter (
   input  wire                                       clock,
   input  wire                                       reset,
   input  wire                                       req_push,
   output logic                                      req_full,
   input  jtrl_pkg::req_word_type                    req_word,
   output logic                                      rsp_empty,
   input  wire                                       rsp_pop,
   output jtrl_pkg::rsp_word_type                    rsp_word,
   input  wire                                       csr_write_enable,
   input  wire [jtrl_pkg::CSR_INDEX_W-1:0]           csr_index,
   input  wire [jtrl_pkg::CSR_DATA_W-1:0]            csr_write_data
);
   import jtrl_pkg::*;

   cfg_type cfg_ff;
   cmd_type push_word, head;
   logic cmdq_push, cmd_pop;
   cmdq_wr_type wr_status;
   cmdq_rd_type rd_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blend_alpha <= 17'd16384;
         cfg_ff.velocity_step_limit <= 31'd58720;
         cfg_ff.accel_step_limit <= 31'd2517;
         cfg_ff.extra_step_limit <= 31'd134218;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_BLEND_ALPHA: cfg_ff.blend_alpha <= csr_write_data[16:0];
            CSR_VELOCITY_STEP_LIMIT: cfg_ff.velocity_step_limit <= csr_write_data;
            CSR_ACCEL_STEP_LIMIT: cfg_ff.accel_step_limit <= csr_write_data;
            CSR_EXTRA_STEP_LIMIT: cfg_ff.extra_step_limit <= csr_write_data;
            default: ;
         endcase
      end
   end

   jtrl_front u_front (
      .req_push  (req_push),
      .req_word  (req_word),
      .req_full  (req_full),
      .cmdq_full (wr_status.full),
      .cmdq_push (cmdq_push),
      .cmdq_word (push_word)
   );

   jtrl_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmdq_push),
      .push_word (push_word),
      .pop       (cmd_pop),
      .head      (head),
      .wr_status (wr_status),
      .rd_status (rd_status)
   );

   jtrl_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .cmd         (head),
      .cmdq_status (rd_status),
      .cmd_pop     (cmd_pop),
      .rsp_word    (rsp_word),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop)
   );

endmodule
`default_nettype wire
